FILE: sv/assert_macros.svh
// assertion macros used by sorted_id_set_intersection
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: sv/sidi_pkg.sv
// types and constants for the sorted id set intersection block
// no dependencies
package sidi_pkg;
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_POP,
    ST_FIN,
    ST_OUT
  } sidi_state_t;

  localparam logic [0:0] REG_NUM_SETS = 1'd0;
  localparam logic [0:0] REG_ID_WIDTH = 1'd1;
endpackage

FILE: sv/sorted_id_set_intersection.sv
// sorted id set intersection: k-way intersection of ascending id lists
// uses sidi_pkg, sidi_ram and assert_macros.svh
//
// usage: ids arrive on the input channel (valid/stall), each tagged with a set
// index and a last flag. ids are queued per set in one ram. after each input
// transaction the block scans heads: one ram read per active set to find the
// largest head, then a second pass that pops smaller heads. passes repeat
// until a queue is empty or all heads match. one transaction is taken at a
// time; a pass steps through the scan reads for the max, a wait state, a pop
// read of each head (popping it when smaller) and a closing state; the reads
// run one after another since the queue ram has a single read port.
// at most one result transaction follows each input: match, run finished
// and/or overflow. the result sits in an output register; while the receiver
// stalls it, no new input is accepted.
// reset clears all queue pointers, counts and end flags; ram contents need
// no clearing. configuration writes are taken any time and used at once.
`include "assert_macros.svh"
module sorted_id_set_intersection import sidi_pkg::*; #(
  parameter int MAX_SETS    = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  set_index,
  input  logic [63:0] id_value,
  input  logic        last_of_set,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        match_found,
  output logic [63:0] match_id,
  output logic        run_finished,
  output logic        overflow
);
  localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = SW + QW;
  localparam int NW = $clog2(MAX_SETS + 1);

  sidi_state_t state, state_next;

  logic [3:0]  num_sets;
  logic        id_is_64bit;
  logic [QW-1:0] queue_head  [MAX_SETS];
  logic [CW-1:0] queue_count [MAX_SETS];
  logic [MAX_SETS-1:0] set_ended;

  logic [SW:0]   idx;
  logic [63:0]   top;
  logic          same;
  logic          rd_pend;
  logic [NW-1:0] nact;

  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;
  logic [AW-1:0] raddr;
  logic [63:0]   rdata;
  logic [SW-1:0] rd_set;
  logic [31:0]   wsum;

  function automatic logic [QW-1:0] head_inc(logic [QW-1:0] h);
    return (32'(h) == QUEUE_DEPTH - 1) ? '0 : h + 1'b1;
  endfunction

  always_comb begin
    if (num_sets < 4'd2) begin
      nact = NW'(2);
    end else if (32'(num_sets) > MAX_SETS) begin
      nact = NW'(MAX_SETS);
    end else begin
      nact = NW'(num_sets);
    end
  end

  logic          in_acc;
  logic          in_active;
  logic [SW-1:0] in_set;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_set    = SW'(set_index);
  assign in_active = (32'(set_index) < 32'(nact)) && (32'(set_index) < MAX_SETS)
                     && !set_ended[in_set];

  assign we    = in_acc && in_active && (queue_count[in_set] < CW'(QUEUE_DEPTH));
  assign wsum  = 32'(queue_head[in_set]) + 32'(queue_count[in_set]);
  assign waddr = {in_set,
                  QW'((wsum >= 32'(QUEUE_DEPTH)) ? wsum - 32'(QUEUE_DEPTH) : wsum)};
  assign wdata = id_is_64bit ? id_value : {32'd0, id_value[31:0]};

  assign rd_set = idx[SW-1:0];
  assign raddr  = {rd_set, queue_head[rd_set]};

  sidi_ram #(.WIDTH(64), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic any_empty;
  logic fin_cond;
  always_comb begin
    any_empty = 1'b0;
    fin_cond  = 1'b0;
    for (int i = 0; i < MAX_SETS; i++) begin
      if (i < 32'(nact)) begin
        if (queue_count[i] == '0) any_empty = 1'b1;
        if (set_ended[i] && queue_count[i] == '0) fin_cond = 1'b1;
      end
    end
  end

  logic [SW-1:0] rd_prev;
  logic          idx_last;
  assign idx_last = (32'(idx) + 1 >= 32'(nact));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      num_sets    <= 4'd2;
      id_is_64bit <= 1'b0;
      set_ended   <= '0;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
      for (int i = 0; i < MAX_SETS; i++) begin
        queue_head[i]  <= '0;
        queue_count[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_SETS: num_sets    <= cfg_data;
          REG_ID_WIDTH: id_is_64bit <= cfg_data[0];
          default: ;
        endcase
      end
      rd_pend <= ((state == ST_SCAN) && !any_empty) || ((state == ST_POP) && !rd_pend);
      rd_prev <= rd_set;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            overflow     <= in_active && !we;
            match_found  <= 1'b0;
            match_id     <= '0;
            run_finished <= 1'b0;
            idx          <= '0;
            top          <= '0;
            same         <= 1'b1;
            if (we) begin
              queue_count[in_set] <= queue_count[in_set] + 1'b1;
              if (last_of_set) set_ended[in_set] <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (!any_empty) begin
            if (rd_pend) begin
              if (rdata > top) top <= rdata;
            end
            if (!idx_last) idx <= idx + 1'b1;
          end
        end
        ST_WAIT: begin
          if (rdata > top) top <= rdata;
          idx  <= '0;
          same <= 1'b1;
        end
        ST_POP: begin
          if (rd_pend) begin
            if (rdata < top) begin
              queue_head[rd_prev]  <= head_inc(queue_head[rd_prev]);
              queue_count[rd_prev] <= queue_count[rd_prev] - 1'b1;
              same <= 1'b0;
            end
            if (!idx_last) idx <= idx + 1'b1;
          end
        end
        ST_FIN: begin
          if (same) begin
            for (int i = 0; i < MAX_SETS; i++) begin
              if (i < 32'(nact)) begin
                queue_head[i]  <= head_inc(queue_head[i]);
                queue_count[i] <= queue_count[i] - 1'b1;
              end
            end
            match_found <= 1'b1;
            match_id    <= top;
          end
          idx <= '0;
          top <= '0;
        end
        ST_OUT: begin
          if (!out_valid) begin
            if (fin_cond) begin
              run_finished <= 1'b1;
              set_ended    <= '0;
              for (int i = 0; i < MAX_SETS; i++) begin
                queue_head[i]  <= '0;
                queue_count[i] <= '0;
              end
            end
            if (fin_cond || match_found || overflow) out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  logic out_done;
  assign out_done = out_valid && !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc) state_next = ST_SCAN;
      ST_SCAN: begin
        if (any_empty) state_next = ST_OUT;
        else if (idx_last) state_next = ST_WAIT;
      end
      ST_WAIT: state_next = ST_POP;
      ST_POP:  if (rd_pend && idx_last) state_next = ST_FIN;
      ST_FIN:  state_next = same ? ST_OUT : ST_SCAN;
      ST_OUT: begin
        if (out_done) state_next = ST_IDLE;
        else if (!out_valid && !(fin_cond || match_found || overflow)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_out_only_in_out, clk, rst, !out_valid || state == ST_OUT)
  `ASSERT_IMPL(a_out_has_flag, clk, rst, !out_valid || match_found || run_finished || overflow)
  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_acc, state == ST_SCAN)
endmodule

FILE: sv/sidi_ram.sv
// generic single-port-write, one-read synchronous ram
// no dependencies
module sidi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
